// ===== src/sha1e_pkg.sv =====
// Shared types and constants of the SHA-1 hash engine.
package sha1e_pkg;

  // One message word as it travels from the front end through the queue.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  cnt;   // valid bytes from the top, already limited to 0..4
    logic        last;
  } q_item_t;

  // Queue side-band between the queue and the back end.
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PAD,
    ST_ZERO,
    ST_LEN,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } back_state_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_BYTE,
    WR_WORD
  } buf_wr_t;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam logic [31:0] K_ROUND [4] = '{
    32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
  };

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [2:0] WORD_BYTES = 3'd4;
  localparam logic [5:0] LEN_POS    = 6'd56;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [6:0] ROUND_P1   = 7'd20;
  localparam logic [6:0] ROUND_P2   = 7'd40;
  localparam logic [6:0] ROUND_P3   = 7'd60;
  localparam logic [2:0] LAST_DIGEST = 3'd4;

endpackage

// ===== src/sha1e_front.sv =====
// Input stage: takes message words, limits the byte count and holds one item for the queue.
module sha1e_front
  import sha1e_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_word,
  input  logic [2:0]  in_cnt,
  input  logic        in_last,
  output logic        push,
  input  logic        push_ready,
  output q_item_t     push_item
);

  logic    hold_valid;
  q_item_t hold;
  q_item_t cls;

  // Counts above four behave as a full word.
  always_comb begin
    cls.word = in_word;
    cls.cnt  = (in_cnt > WORD_BYTES) ? WORD_BYTES : in_cnt;
    cls.last = in_last;
  end

  assign in_ready  = !hold_valid || push_ready;
  assign push      = hold_valid;
  assign push_item = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold <= cls;
    end
  end

endmodule

// ===== src/sha1e_fifo.sv =====
// Short queue of message items between the front end and the compression back end.
module sha1e_fifo
  import sha1e_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    push_ready,
  input  q_item_t push_item,
  input  logic    pop,
  output q_head_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  q_item_t       mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count != CNT_FULL);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== src/sha1e_core.sv =====
// Back end: byte packing into the block buffer, padding, 80-round compression and digest output.
module sha1e_core
  import sha1e_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  q_head_t     head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word,
  output logic        out_last
);

  back_state_t state, state_next;
  back_state_t ret, ret_next;
  logic [6:0]  rnd, rnd_next;
  logic [5:0]  pos, pos_next;
  logic [60:0] total, total_next;
  logic [2:0]  bi, bi_next;
  q_item_t     item;
  logic        load_item;

  logic [31:0] hv [5];
  logic [31:0] a, b, c, d, e;
  logic [31:0] w [16];

  buf_wr_t     wr_kind;
  logic [31:0] wr_data;
  logic [2:0]  step;
  logic        start_comp;
  logic        len_wr;
  logic        do_round;
  logic        do_add;
  logic        out_load;
  logic        hash_init;

  logic [6:0]  pos_sum;
  logic [2:0]  nbi;
  logic        item_done;
  logic        wrap;
  logic [7:0]  cur_byte;
  logic [63:0] bit_len;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;
  logic [31:0] w_new;

  always_comb begin
    case (bi[1:0])
      2'd0:    cur_byte = item.word[31:24];
      2'd1:    cur_byte = item.word[23:16];
      2'd2:    cur_byte = item.word[15:8];
      default: cur_byte = item.word[7:0];
    endcase
  end

  assign bit_len = {total, 3'b000};

  // Round function and constant by round group.
  always_comb begin
    if (rnd < ROUND_P1) begin
      f = d ^ (b & (c ^ d));
      k = K_ROUND[0];
    end else if (rnd < ROUND_P2) begin
      f = b ^ c ^ d;
      k = K_ROUND[1];
    end else if (rnd < ROUND_P3) begin
      f = (b & c) | (d & (b | c));
      k = K_ROUND[2];
    end else begin
      f = b ^ c ^ d;
      k = K_ROUND[3];
    end
  end

  assign t     = {a[26:0], a[31:27]} + f + e + k + w[0];
  assign w_new = {w[13][30:0] ^ w[8][30:0] ^ w[2][30:0] ^ w[0][30:0],
                  w[13][31] ^ w[8][31] ^ w[2][31] ^ w[0][31]};

  assign pos_sum = {1'b0, pos} + {4'd0, step};
  assign nbi     = bi + step;
  assign wrap    = (step != '0) && pos_sum[6];

  always_comb begin
    state_next = state;
    ret_next   = ret;
    rnd_next   = rnd;
    pos_next   = pos;
    total_next = total;
    bi_next    = bi;
    pop        = 1'b0;
    load_item  = 1'b0;
    wr_kind    = WR_NONE;
    wr_data    = '0;
    step       = '0;
    start_comp = 1'b0;
    len_wr     = 1'b0;
    do_round   = 1'b0;
    do_add     = 1'b0;
    out_load   = 1'b0;
    hash_init  = 1'b0;
    item_done  = 1'b0;

    case (state)
      ST_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          load_item  = 1'b1;
          bi_next    = '0;
          state_next = ST_LOAD;
        end
      end

      ST_LOAD: begin
        if (bi < item.cnt) begin
          if (bi == '0 && item.cnt == WORD_BYTES && pos[1:0] == 2'd0) begin
            wr_kind = WR_WORD;
            wr_data = item.word;
            step    = WORD_BYTES;
          end else begin
            wr_kind = WR_BYTE;
            wr_data = {24'd0, cur_byte};
            step    = 3'd1;
          end
        end
        item_done  = (nbi >= item.cnt);
        bi_next    = nbi;
        pos_next   = pos_sum[5:0];
        total_next = total + 61'(step);
        if (wrap) begin
          start_comp = 1'b1;
          state_next = ST_ROUND;
          ret_next   = !item_done ? ST_LOAD : (item.last ? ST_PAD : ST_IDLE);
        end else if (item_done) begin
          if (item.last) begin
            state_next = ST_PAD;
          end else if (head.valid) begin
            // take the next item straight away
            pop       = 1'b1;
            load_item = 1'b1;
            bi_next   = '0;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end

      ST_PAD: begin
        wr_kind  = WR_BYTE;
        wr_data  = {24'd0, PAD_BYTE};
        step     = 3'd1;
        pos_next = pos_sum[5:0];
        if (wrap) begin
          start_comp = 1'b1;
          state_next = ST_ROUND;
          ret_next   = ST_ZERO;
        end else begin
          state_next = ST_ZERO;
        end
      end

      ST_ZERO: begin
        if (pos == LEN_POS) begin
          state_next = ST_LEN;
        end else begin
          wr_data = '0;
          if (pos[1:0] == 2'd0) begin
            wr_kind = WR_WORD;
            step    = WORD_BYTES;
          end else begin
            wr_kind = WR_BYTE;
            step    = 3'd1;
          end
          pos_next = pos_sum[5:0];
          if (wrap) begin
            start_comp = 1'b1;
            state_next = ST_ROUND;
            ret_next   = ST_ZERO;
          end
        end
      end

      ST_LEN: begin
        len_wr     = 1'b1;
        start_comp = 1'b1;
        state_next = ST_ROUND;
        ret_next   = ST_OUT;
      end

      ST_ROUND: begin
        do_round = 1'b1;
        if (rnd == LAST_ROUND) begin
          rnd_next   = '0;
          state_next = ST_ADD;
        end else begin
          rnd_next = rnd + 7'd1;
        end
      end

      ST_ADD: begin
        do_add     = 1'b1;
        state_next = ret;
      end

      ST_OUT: begin
        if (!out_valid || out_ready) begin
          out_load = 1'b1;
          if (rnd[2:0] == LAST_DIGEST) begin
            hash_init  = 1'b1;
            rnd_next   = '0;
            pos_next   = '0;
            total_next = '0;
            state_next = ST_IDLE;
          end else begin
            rnd_next = rnd + 7'd1;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret       <= ST_IDLE;
      rnd       <= '0;
      pos       <= '0;
      total     <= '0;
      bi        <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        hv[i] <= H_INIT[i];
      end
    end else begin
      state <= state_next;
      ret   <= ret_next;
      rnd   <= rnd_next;
      pos   <= pos_next;
      total <= total_next;
      bi    <= bi_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (hash_init) begin
        for (int i = 0; i < 5; i++) begin
          hv[i] <= H_INIT[i];
        end
      end else if (do_add) begin
        hv[0] <= hv[0] + a;
        hv[1] <= hv[1] + b;
        hv[2] <= hv[2] + c;
        hv[3] <= hv[3] + d;
        hv[4] <= hv[4] + e;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_item) begin
      item <= head.item;
    end
    if (out_load) begin
      out_word <= hv[rnd[2:0]];
      out_last <= (rnd[2:0] == LAST_DIGEST);
    end
    if (start_comp) begin
      a <= hv[0];
      b <= hv[1];
      c <= hv[2];
      d <= hv[3];
      e <= hv[4];
    end else if (do_round) begin
      a <= t;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  // Block buffer doubles as the message schedule: shift one word per round.
  always_ff @(posedge clk) begin
    if (do_round) begin
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i+1];
      end
      w[15] <= w_new;
    end else if (len_wr) begin
      w[14] <= bit_len[63:32];
      w[15] <= bit_len[31:0];
    end else if (wr_kind == WR_WORD) begin
      w[pos[5:2]] <= wr_data;
    end else if (wr_kind == WR_BYTE) begin
      case (pos[1:0])
        2'd0:    w[pos[5:2]]        <= {wr_data[7:0], 24'd0};
        2'd1:    w[pos[5:2]][23:16] <= wr_data[7:0];
        2'd2:    w[pos[5:2]][15:8]  <= wr_data[7:0];
        default: w[pos[5:2]][7:0]   <= wr_data[7:0];
      endcase
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("item taken from an empty queue");

  a_len_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LEN) |-> (pos == LEN_POS))
    else $error("length written at wrong buffer position");

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && rnd == LAST_ROUND) |=> (state == ST_ADD))
    else $error("compression did not finish after the last round");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> (rnd <= LAST_ROUND))
    else $error("round index out of range");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> (rnd <= 7'(LAST_DIGEST)))
    else $error("digest index out of range");

endmodule

// ===== src/sha1_hash_engine.sv =====
// SHA-1 hash engine top level: front end, item queue and compression back end.
//
// Input stream (s_*): one big-endian message word per item with the number of
// valid bytes counted from the top (counts above four act as four); s_tlast
// marks the final word of a message, which may carry zero to four bytes.
// Output stream (m_*): the five digest words H0..H4 in order, m_tlast on H4.
// The block then starts a fresh message from the initial hash values.
// Back end: full, word-aligned items are written into the block buffer as
// whole words, and each completed 64-byte block is compressed (80 rounds on
// one round unit, then the hash update) before packing resumes; unaligned
// or short items are written a byte at a time.
// After a last word the back end writes the pad byte, the zero fill and the
// 64-bit length, compresses each of the one or two final blocks (80 rounds,
// one hash update), then sends the digest words.
// A queue of QUEUE_DEPTH items plus one holding register decouples input from
// the compression unit, so input is taken while rounds run.
// Reset clears the queue, the byte counters and loads the initial hash values.
// When m_tready is low the digest word waits in the output register and the
// back end holds; input keeps being taken until the queue fills.
module sha1_hash_engine
  import sha1e_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] data_word, [34:32] byte_count, zero fill
  input  logic        s_tlast,   // last_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic        m_tlast    // digest_last
);

  logic    push;
  logic    push_ready;
  q_item_t push_item;
  logic    pop;
  q_head_t head;

  sha1e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_word    (s_tdata[31:0]),
    .in_cnt     (s_tdata[34:32]),
    .in_last    (s_tlast),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  sha1e_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop        (pop),
    .head       (head)
  );

  sha1e_core u_core (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule
